[design/amf_pkg.sv]
// ----------------------------------------------------------------------------
// amf_pkg: shared types and constants of the adaptive median filter
// Sizes of the window and line store, payload words and selector control.
// ----------------------------------------------------------------------------
package amf_pkg;

  localparam int MAX_WINDOW = 7;
  localparam int LINE_WIDTH = 2048;
  localparam int NLINES     = MAX_WINDOW - 1;
  localparam int NCELL      = MAX_WINDOW * MAX_WINDOW;
  localparam int MLIM       = (MAX_WINDOW - 1) | 1;

  localparam int COL_W  = $clog2(LINE_WIDTH);
  localparam int ROW_W  = 12;
  localparam int DIM_W  = 12;
  localparam int SCFG_W = 3;
  localparam int SIZE_W = $clog2(MAX_WINDOW + 1);
  localparam int RANK_W = $clog2(NCELL + 1);
  localparam int SLOT_W = (NLINES > 1) ? $clog2(NLINES) : 1;
  localparam int CIDX_W = $clog2(NCELL);
  localparam int NSEL   = 3;

  // selector lanes
  localparam int SEL_MIN = 0;
  localparam int SEL_MED = 1;
  localparam int SEL_MAX = 2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SIZE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE     = 2'd3;

  typedef logic [7:0]        pix_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [COL_W:0]    cnt_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ROW_W:0]    rowc_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [SCFG_W-1:0] scfg_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CIDX_W-1:0] cidx_t;

  typedef struct packed {
    pix_t pixel_in;
    logic frame_start;
  } in_word_t;

  typedef struct packed {
    pix_t pixel_out;
    logic row_end;
    logic frame_end;
  } out_word_t;

  typedef struct packed {
    pix_t                hi_mask;
    pix_t                bit_mask;
    pix_t [NSEL-1:0]     prefix;
  } sel_ctrl_t;

endpackage

[design/amf_line_bank.sv]
// ----------------------------------------------------------------------------
// amf_line_bank: one line of the line store
// Single-port RAM, read-before-write, registered read data.
// ----------------------------------------------------------------------------
module amf_line_bank (
  input  logic          clk,
  input  logic          we,
  input  amf_pkg::col_t addr,
  input  amf_pkg::pix_t wdata,
  output amf_pkg::pix_t rdata
);

  amf_pkg::pix_t mem [amf_pkg::LINE_WIDTH];

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

[design/amf_cell.sv]
// ----------------------------------------------------------------------------
// amf_cell: one window cell
// Holds one pixel, shifts from its neighbor, flags a radix-select match.
// ----------------------------------------------------------------------------
module amf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  amf_pkg::pix_t              pix_in,
  input  amf_pkg::sel_ctrl_t         ctrl,
  input  logic                       in_win,
  output amf_pkg::pix_t              pix,
  output logic [amf_pkg::NSEL-1:0]   match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (shift) begin
      pix <= pix_in;
    end
  end

  // match: prefix above the current bit agrees and the current bit is zero
  always_comb begin
    for (int j = 0; j < amf_pkg::NSEL; j++) begin
      match[j] = in_win && (((pix ^ ctrl.prefix[j]) & ctrl.hi_mask) == '0)
                 && ((pix & ctrl.bit_mask) == '0);
    end
  end

endmodule

[design/adaptive_median_filter_core.sv]
// ----------------------------------------------------------------------------
// adaptive_median_filter_core: streaming adaptive median filter
// Line store, a shifting chain of window cells and a bit-serial rank selector.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_stall  | in_word_t  (pixel_in, frame_start)
//  out     | output    | out_valid / out_stall| out_word_t (pixel_out, row_end, frame_end)
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
//  A word with no result passes the accept step, then line read + window shift.
//  A word with a result then runs, for each window size tried,
//  8 radix-select steps (one bit a cycle) plus one decide step.
//  After reset the line store is cleared over all LINE_WIDTH (2048) columns
//  with in_stall high; config writes are taken during that time.
//  The result sits in an output register; a stalled result holds the decide
//  step until the register frees up.
// ----------------------------------------------------------------------------
module adaptive_median_filter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  amf_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output amf_pkg::out_word_t               out_data,
  input  logic                             cfg_write,
  input  logic [amf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [amf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOAD   = 2'd1;
  localparam logic [1:0] S_SEL    = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  localparam int MW = amf_pkg::MAX_WINDOW;

  // configuration registers
  amf_pkg::dim_t  image_width, image_height;
  amf_pkg::scfg_t start_size, max_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= amf_pkg::dim_t'(640);
      image_height <= amf_pkg::dim_t'(480);
      start_size   <= amf_pkg::scfg_t'(3);
      max_size     <= amf_pkg::scfg_t'(7);
    end else if (cfg_write) begin
      unique case (cfg_index)
        amf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        amf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        amf_pkg::REG_START_SIZE:   start_size   <= cfg_data[amf_pkg::SCFG_W-1:0];
        amf_pkg::REG_MAX_SIZE:     max_size     <= cfg_data[amf_pkg::SCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: clamps and forced odd sizes
  amf_pkg::cnt_t  w_eff;
  amf_pkg::dim_t  h_eff;
  amf_pkg::size_t m_eff, s_eff;

  always_comb begin
    int mm, ss;
    if (int'(image_width) > amf_pkg::LINE_WIDTH) begin
      w_eff = amf_pkg::cnt_t'(amf_pkg::LINE_WIDTH);
    end else if (image_width == '0) begin
      w_eff = amf_pkg::cnt_t'(1);
    end else begin
      w_eff = amf_pkg::cnt_t'(image_width);
    end
    h_eff = (image_height == '0) ? amf_pkg::dim_t'(1) : image_height;
    mm = int'(max_size) | 1;
    ss = int'(start_size) | 1;
    if (mm < 3) mm = 3;
    if (mm > amf_pkg::MLIM) mm = amf_pkg::MLIM;
    if (ss < 3) ss = 3;
    if (ss > mm) ss = mm;
    m_eff = amf_pkg::size_t'(mm);
    s_eff = amf_pkg::size_t'(ss);
  end

  // state
  logic [1:0]       state;
  logic             clearing;
  amf_pkg::col_t    clr_addr;
  amf_pkg::col_t    col_q;
  amf_pkg::row_t    row_q;
  amf_pkg::slot_t   slot_q;

  // per-word latches
  amf_pkg::pix_t    pix_q;
  amf_pkg::slot_t   slot_i;
  logic             has_q, re_q, fe_q;
  amf_pkg::size_t   m_q, k_q;
  amf_pkg::size_t   s_q;

  // selectors
  amf_pkg::pix_t [amf_pkg::NSEL-1:0] pref;
  amf_pkg::rank_t                    tgt  [amf_pkg::NSEL];
  amf_pkg::rank_t                    cnt  [amf_pkg::NSEL];
  logic [2:0]                        bit_idx;

  logic accept;
  assign in_stall = clearing || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // position of the accepted word
  amf_pkg::col_t  col_a;
  amf_pkg::row_t  row_a;
  amf_pkg::slot_t slot_a;
  amf_pkg::cnt_t  col_p1;
  amf_pkg::rowc_t row_p1;
  logic           has_a, re_a, fe_a;

  always_comb begin
    col_a  = in_data.frame_start ? '0 : col_q;
    row_a  = in_data.frame_start ? '0 : row_q;
    slot_a = in_data.frame_start ? '0 : slot_q;
    col_p1 = amf_pkg::cnt_t'(col_a) + amf_pkg::cnt_t'(1);
    row_p1 = amf_pkg::rowc_t'(row_a) + amf_pkg::rowc_t'(1);
    has_a  = (row_p1 >= amf_pkg::rowc_t'(m_eff)) && (col_p1 >= amf_pkg::cnt_t'(m_eff));
    re_a   = (col_p1 == w_eff);
    fe_a   = re_a && (amf_pkg::rowc_t'(row_a) == amf_pkg::rowc_t'(h_eff) - 1'b1);
  end

  // counters and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == amf_pkg::col_t'(amf_pkg::LINE_WIDTH - 1)) clearing <= 1'b0;
      end
      if (accept) begin
        if (col_p1 >= w_eff) begin
          col_q <= '0;
          if (row_p1 >= amf_pkg::rowc_t'(h_eff)) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_p1[amf_pkg::ROW_W-1:0];
            slot_q <= (int'(slot_a) == amf_pkg::NLINES - 1) ? '0 : slot_a + 1'b1;
          end
        end else begin
          col_q  <= col_p1[amf_pkg::COL_W-1:0];
          row_q  <= row_a;
          slot_q <= slot_a;
        end
      end
    end
  end

  // line store: one bank per stored row, all read at the word's column
  amf_pkg::pix_t bank_rd [amf_pkg::NLINES];
  amf_pkg::col_t bank_addr;
  assign bank_addr = clearing ? clr_addr : col_a;

  for (genvar b = 0; b < amf_pkg::NLINES; b++) begin : g_bank
    logic          we;
    amf_pkg::pix_t wd;
    assign we = clearing || (accept && (int'(slot_a) == b));
    assign wd = clearing ? '0 : in_data.pixel_in;
    amf_line_bank u_bank (
      .clk   (clk),
      .we    (we),
      .addr  (bank_addr),
      .wdata (wd),
      .rdata (bank_rd[b])
    );
  end

  // window row r takes bank (slot + r) mod NLINES
  amf_pkg::pix_t line_row [amf_pkg::NLINES];
  always_comb begin
    int idx;
    for (int r = 0; r < amf_pkg::NLINES; r++) begin
      idx = int'(slot_i) + r;
      if (idx >= amf_pkg::NLINES) idx = idx - amf_pkg::NLINES;
      line_row[r] = bank_rd[amf_pkg::slot_t'(idx)];
    end
  end

  // window geometry for the size under test
  amf_pkg::size_t c0, half;
  assign c0   = amf_pkg::size_t'(MW - 1 - int'(m_q >> 1));
  assign half = k_q >> 1;

  amf_pkg::sel_ctrl_t ctrl;
  assign ctrl.hi_mask  = 8'hFE << bit_idx;
  assign ctrl.bit_mask = 8'h01 << bit_idx;
  assign ctrl.prefix   = pref;

  amf_pkg::pix_t             cell_pix   [amf_pkg::NCELL];
  logic [amf_pkg::NSEL-1:0]  cell_match [amf_pkg::NCELL];

  for (genvar r = 0; r < MW; r++) begin : g_row
    for (genvar c = 0; c < MW; c++) begin : g_col
      amf_pkg::pix_t src;
      logic          win;
      if (c == MW - 1) begin : g_edge
        if (r == MW - 1) begin : g_new
          assign src = pix_q;
        end else begin : g_line
          assign src = line_row[r];
        end
      end else begin : g_inner
        assign src = cell_pix[r*MW + c + 1];
      end
      assign win = (r + int'(half) >= int'(c0)) && (r <= int'(c0) + int'(half)) &&
                   (c + int'(half) >= int'(c0)) && (c <= int'(c0) + int'(half));
      amf_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (state == S_LOAD),
        .pix_in (src),
        .ctrl   (ctrl),
        .in_win (win),
        .pix    (cell_pix[r*MW + c]),
        .match  (cell_match[r*MW + c])
      );
    end
  end

  // match counts per selector
  always_comb begin
    for (int j = 0; j < amf_pkg::NSEL; j++) begin
      cnt[j] = '0;
      for (int i = 0; i < amf_pkg::NCELL; i++) begin
        cnt[j] = cnt[j] + amf_pkg::rank_t'(cell_match[i][j]);
      end
    end
  end

  // centre pixel and decision
  amf_pkg::pix_t zxy, mn, med, mx;
  amf_pkg::cidx_t cidx;
  logic           level_ok;
  assign cidx     = amf_pkg::cidx_t'(int'(c0) * MW + int'(c0));
  assign zxy      = cell_pix[cidx];
  assign mn       = pref[amf_pkg::SEL_MIN];
  assign med      = pref[amf_pkg::SEL_MED];
  assign mx       = pref[amf_pkg::SEL_MAX];
  assign level_ok = (mn < med) && (med < mx);

  logic          done;
  amf_pkg::pix_t result;
  assign done   = level_ok || (k_q >= m_q);
  assign result = (level_ok && (mn < zxy) && (zxy < mx)) ? zxy : med;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // target rank of lane j for a window of side k: 0, n/2, n-1
  function automatic amf_pkg::rank_t target_of(input amf_pkg::size_t k, input int j);
    int n;
    n = int'(k) * int'(k);
    if (j == amf_pkg::SEL_MIN) begin
      return '0;
    end else if (j == amf_pkg::SEL_MED) begin
      return amf_pkg::rank_t'(n >> 1);
    end else begin
      return amf_pkg::rank_t'(n - 1);
    end
  endfunction

  amf_pkg::size_t k_next;
  assign k_next = k_q + amf_pkg::size_t'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the decide step reloads the register in the cycle it frees up
      if (out_valid && !out_stall && !(state == S_DECIDE && done)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_LOAD;
        end
        S_LOAD: begin
          if (has_q) begin
            k_q     <= s_q;
            pref    <= '0;
            bit_idx <= 3'd7;
            for (int j = 0; j < amf_pkg::NSEL; j++) begin
              tgt[j] <= target_of(s_q, j);
            end
            state   <= S_SEL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SEL: begin
          for (int j = 0; j < amf_pkg::NSEL; j++) begin
            if (tgt[j] >= cnt[j]) begin
              pref[j] <= pref[j] | ctrl.bit_mask;
              tgt[j]  <= tgt[j] - cnt[j];
            end
          end
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == 3'd0) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!done) begin
            k_q     <= k_next;
            pref    <= '0;
            bit_idx <= 3'd7;
            for (int j = 0; j < amf_pkg::NSEL; j++) begin
              tgt[j] <= target_of(k_next, j);
            end
            state   <= S_SEL;
          end else if (out_free) begin
            out_valid          <= 1'b1;
            out_data.pixel_out <= result;
            out_data.row_end   <= re_q;
            out_data.frame_end <= fe_q;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // word latches (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q  <= in_data.pixel_in;
      slot_i <= slot_a;
      has_q  <= has_a;
      re_q   <= re_a;
      fe_q   <= fe_a;
      m_q    <= m_eff;
      s_q    <= s_eff;
    end
  end

endmodule

[design/amf_checker.sv]
// ----------------------------------------------------------------------------
// amf_checker: port-level checks of the adaptive median filter
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module amf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input amf_pkg::out_word_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // one word at a time: an accepted word blocks the input on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  // last result of a frame is also last of its row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.frame_end || out_data.row_end))
    else $error("frame_end without row_end");

endmodule

bind adaptive_median_filter_core amf_checker u_amf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
